>>> rtl/core/b64lw_pkg.sv
// shared types, character constants and the base64 alphabet for the line-wrapping encoder
// no dependencies
package b64lw_pkg;

    localparam int LINE_LEN_W     = 10;
    localparam int QUEUE_DEPTH    = 2;
    localparam int SYMS_MAX       = 4;
    localparam int SYM_CNT_W      = 3;
    localparam logic [LINE_LEN_W-1:0] LINE_LEN_RESET = 10'd76;
    localparam logic [LINE_LEN_W-1:0] WRAP_MIN       = 10'd8;
    localparam logic [LINE_LEN_W-1:0] COL_MAX        = 10'd1023;

    // register indexes on the configuration port
    localparam logic REG_LINE_LENGTH = 1'b0;
    localparam logic REG_FOLD_TAB    = 1'b1;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    // one classified request: its characters before any line breaks
    typedef struct packed {
        logic [SYMS_MAX-1:0][7:0] chars;
        logic [SYM_CNT_W-1:0]     count;
        logic                     fin;
    } entry_t;

    // wrapping controls seen by the back end
    typedef struct packed {
        logic [LINE_LEN_W-1:0] line_length;
        logic                  fold_tab;
    } wrap_cfg_t;

    // 6-bit code to standard alphabet letter
    function automatic logic [7:0] b64_char(input logic [5:0] code);
        logic [7:0] c;
        c = {2'b00, code};
        if (code < 6'd26)      return 8'h41 + c;
        else if (code < 6'd52) return 8'h61 + c - 8'd26;
        else if (code < 6'd62) return 8'h30 + c - 8'd52;
        else if (code == 6'd62) return 8'h2B;
        else                   return 8'h2F;
    endfunction

endpackage

>>> rtl/core/b64lw_front.sv
// front end: accepts message bytes, tracks the 3-byte group and builds the characters
// depends on b64lw_pkg
module b64lw_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_data_byte,
    input  logic            s_final_byte,
    input  logic            q_full,
    output logic            q_push,
    output b64lw_pkg::entry_t q_entry
);
    import b64lw_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [5:0] carry_reg, carry_next;
    logic [5:0] flush_code;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // classify the byte by its place in the group
    always_comb begin
        q_entry       = '0;
        q_entry.chars = {SYMS_MAX{CHAR_PAD}};
        q_entry.fin   = s_final_byte;
        phase_next    = phase_reg;
        carry_next    = carry_reg;
        flush_code    = '0;
        case (phase_reg)
            2'd1: begin
                q_entry.chars[0] = b64_char(carry_reg | {2'b00, s_data_byte[7:4]});
                flush_code       = {s_data_byte[3:0], 2'b00};
                q_entry.chars[1] = b64_char(flush_code);
                q_entry.count    = s_final_byte ? 3'd3 : 3'd1;
                carry_next       = flush_code;
                phase_next       = 2'd2;
            end
            2'd2: begin
                q_entry.chars[0] = b64_char(carry_reg | {4'b0000, s_data_byte[7:6]});
                q_entry.chars[1] = b64_char(s_data_byte[5:0]);
                q_entry.count    = 3'd2;
                carry_next       = '0;
                phase_next       = 2'd0;
            end
            default: begin
                q_entry.chars[0] = b64_char(s_data_byte[7:2]);
                flush_code       = {s_data_byte[1:0], 4'b0000};
                q_entry.chars[1] = b64_char(flush_code);
                q_entry.count    = s_final_byte ? 3'd4 : 3'd1;
                carry_next       = flush_code;
                phase_next       = 2'd1;
            end
        endcase
        if (s_final_byte) begin
            phase_next = 2'd0;
            carry_next = '0;
        end
    end

    // group state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            carry_reg <= '0;
        end else if (q_push) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

>>> rtl/core/b64lw_fifo.sv
// short request queue between front and back end, register based
// depends on b64lw_pkg
module b64lw_fifo #(
    parameter int DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  b64lw_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output b64lw_pkg::entry_t head
);
    import b64lw_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    entry_t        mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/b64lw_back.sv
// back end: one char a cycle unless stalled; counts columns, inserts line breaks
// depends on b64lw_pkg
module b64lw_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  b64lw_pkg::wrap_cfg_t cfg,
    input  logic                 q_not_empty,
    input  b64lw_pkg::entry_t    q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_char,
    output logic                 m_run_last,
    output logic                 m_message_done
);
    import b64lw_pkg::*;

    typedef enum logic [2:0] {
        ST_CHAR = 3'b001,
        ST_LF   = 3'b010,
        ST_TAB  = 3'b100
    } back_state_t;

    back_state_t            state_reg, state_next;
    logic [SYM_CNT_W-1:0]   idx_reg, idx_next;
    logic [LINE_LEN_W-1:0]  col_reg, col_next, col_inc;
    logic                   final_brk_reg, final_brk_next;
    logic                   valid_reg;
    logic [7:0]             char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   done_reg;
    logic                   fire, wrap_on, brk_need;

    assign fire     = q_not_empty && (!valid_reg || m_ready);
    assign wrap_on  = cfg.line_length > WRAP_MIN;
    assign brk_need = wrap_on && (col_reg >= cfg.line_length);
    assign col_inc  = (col_reg == COL_MAX) ? col_reg : col_reg + 1'b1;

    // next character and sequencer state
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        final_brk_next = final_brk_reg;
        char_next      = CHAR_CR;
        last_next      = 1'b0;
        case (state_reg)
            ST_CHAR: begin
                if (idx_reg == q_head.count) begin
                    // end of message break after the last character
                    state_next     = ST_LF;
                    final_brk_next = 1'b1;
                    col_next       = '0;
                end else if (brk_need) begin
                    state_next     = ST_LF;
                    final_brk_next = 1'b0;
                    col_next       = '0;
                end else begin
                    char_next = q_head.chars[idx_reg[1:0]];
                    col_next  = col_inc;
                    if (idx_reg == q_head.count - 1'b1) begin
                        if (q_head.fin && wrap_on && col_inc >= cfg.line_length) begin
                            idx_next = idx_reg + 1'b1;
                        end else begin
                            last_next = 1'b1;
                            idx_next  = '0;
                            if (q_head.fin) begin
                                col_next = '0;
                            end
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_LF: begin
                char_next = CHAR_LF;
                if (cfg.fold_tab) begin
                    state_next = ST_TAB;
                end else begin
                    state_next = ST_CHAR;
                    if (final_brk_reg) begin
                        last_next = 1'b1;
                        idx_next  = '0;
                    end
                end
            end
            ST_TAB: begin
                char_next  = CHAR_TAB;
                state_next = ST_CHAR;
                if (final_brk_reg) begin
                    last_next = 1'b1;
                    idx_next  = '0;
                end
            end
            default: begin
                state_next = ST_CHAR;
                idx_next   = '0;
            end
        endcase
    end

    assign q_pop = fire && last_next;

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CHAR;
            idx_reg       <= '0;
            col_reg       <= '0;
            final_brk_reg <= 1'b0;
        end else if (fire) begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            col_reg       <= col_next;
            final_brk_reg <= final_brk_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (fire) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            char_reg <= char_next;
            last_reg <= last_next;
            done_reg <= last_next && q_head.fin;
        end
    end

    assign m_valid        = valid_reg;
    assign m_out_char     = char_reg;
    assign m_run_last     = last_reg;
    assign m_message_done = done_reg;

endmodule

>>> rtl/core/base64_encoder_line_wrap_top.sv
// base64 encoder with optional line wrapping: one byte in, characters out one per cycle unless stalled
// path: an accepted byte is stored in the queue, then its characters pass through the output register
// output: one character per cycle from the back-end sequencer while the receiver is ready; a byte
//   causes 1 to 4 characters, plus 2 or 3 per line break
// reset: synchronous active low, clears group state, column count, queue and output valid;
//   line_length returns to 76 and fold_tab to 0
module base64_encoder_line_wrap_top #(
    parameter int QUEUE_DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_run_last,
    output logic        m_message_done,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [b64lw_pkg::LINE_LEN_W-1:0] cfg_data
);
    import b64lw_pkg::*;

    logic [LINE_LEN_W-1:0] line_length_reg;
    logic                  fold_tab_reg;
    wrap_cfg_t             wrap_cfg;
    entry_t                push_entry, head;
    logic                  push, pop, full, not_empty;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= LINE_LEN_RESET;
            fold_tab_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LINE_LENGTH: line_length_reg <= cfg_data;
                REG_FOLD_TAB:    fold_tab_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign wrap_cfg.line_length = line_length_reg;
    assign wrap_cfg.fold_tab    = fold_tab_reg;

    b64lw_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .q_full       (full),
        .q_push       (push),
        .q_entry      (push_entry)
    );

    b64lw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    b64lw_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (wrap_cfg),
        .q_not_empty    (not_empty),
        .q_head         (head),
        .q_pop          (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_run_last     (m_run_last),
        .m_message_done (m_message_done)
    );

endmodule

>>> tb/base64_encoder_line_wrap_top_test.sv
// self-checking testbench for base64_encoder_line_wrap_top: predicts the encoded characters,
// line breaks and end flags of every accepted byte and checks them against the result channel
// depends on b64lw_pkg and the encoder RTL
`timescale 1ns / 1ps

module base64_encoder_line_wrap_top_test;
    import b64lw_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 12;
    localparam int SETTLE_LEN  = 16;
    localparam int LONG_HOLD   = 80;
    localparam int REPORT_MAX  = 10;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_BYTES = 8;
    localparam int RUN_BYTES   = 20;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // one message byte waiting to be offered
    typedef struct {
        logic [7:0] data;
        logic       fin;
    } msg_byte_t;

    // one predicted output character with its flags
    typedef struct {
        logic [7:0] code;
        logic       run_last;
        logic       done;
    } enc_char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_final_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_char;
    logic        m_run_last;
    logic        m_message_done;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_LINE_LENGTH;
    logic [LINE_LEN_W-1:0] cfg_data = '0;

    base64_encoder_line_wrap_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_run_last    (m_run_last),
        .m_message_done(m_message_done),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // watchdog
    initial begin
        #400_000;
        $display("TB_ERROR");
        $finish;
    end

    msg_byte_t  byte_queue[$];
    enc_char_t  char_expect[$];
    enc_char_t  step_chars[$];
    idle_mode_t idle_mode = IDLE_NONE;
    int         req_sent = 0;
    int         req_accepted = 0;
    int         hold_requests = 0;
    int         hold_served = 0;
    int         hold_left = 0;
    int         mismatch_count = 0;

    // encoder state as the block should hold it
    string                 b64_letters =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [LINE_LEN_W-1:0] line_len_cfg = LINE_LEN_RESET;
    logic                  fold_cfg = 1'b0;
    logic [1:0]            grp_phase = 2'd0;
    logic [5:0]            carry = 6'd0;
    logic [LINE_LEN_W-1:0] col_count = '0;

    function automatic logic [7:0] letter_for(input logic [5:0] code);
        return b64_letters[code];
    endfunction

    task automatic push_char(input logic [7:0] c);
        enc_char_t e;
        e.code = c;
        e.run_last = 1'b0;
        e.done = 1'b0;
        step_chars.push_back(e);
    endtask

    // line break once the column has reached the limit, wrapping active only above 8
    task automatic break_line_if_full();
        if (line_len_cfg > WRAP_MIN && col_count >= line_len_cfg) begin
            push_char(CHAR_CR);
            push_char(CHAR_LF);
            if (fold_cfg)
                push_char(CHAR_TAB);
            col_count = '0;
        end
    endtask

    task automatic put_symbol(input logic [7:0] c);
        break_line_if_full();
        push_char(c);
        if (col_count != COL_MAX)
            col_count = col_count + 1'b1;
    endtask

    // characters caused by one accepted byte
    task automatic encode_byte(input logic [7:0] d, input logic fin);
        enc_char_t tail;
        logic [1:0] ph;
        step_chars.delete();
        ph = (grp_phase == 2'd3) ? 2'd0 : grp_phase;
        case (ph)
            2'd0: begin
                put_symbol(letter_for(d[7:2]));
                carry = {d[1:0], 4'b0000};
                grp_phase = 2'd1;
                if (fin) begin
                    put_symbol(letter_for(carry));
                    put_symbol(CHAR_PAD);
                    put_symbol(CHAR_PAD);
                end
            end
            2'd1: begin
                put_symbol(letter_for(carry | {2'b00, d[7:4]}));
                carry = {d[3:0], 2'b00};
                grp_phase = 2'd2;
                if (fin) begin
                    put_symbol(letter_for(carry));
                    put_symbol(CHAR_PAD);
                end
            end
            default: begin
                put_symbol(letter_for(carry | {4'b0000, d[7:6]}));
                put_symbol(letter_for(d[5:0]));
                carry = 6'd0;
                grp_phase = 2'd0;
            end
        endcase
        if (fin) begin
            break_line_if_full();
            grp_phase = 2'd0;
            carry = 6'd0;
            col_count = '0;
        end
        tail = step_chars.pop_back();
        tail.run_last = 1'b1;
        tail.done = fin;
        step_chars.push_back(tail);
        foreach (step_chars[i])
            char_expect.push_back(step_chars[i]);
    endtask

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 59;
            IDLE_BOTH:   return $urandom_range(0, 99) < 11;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 59;
            IDLE_BOTH:     return $urandom_range(0, 99) < 11;
            default:       return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_MAX)
            $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // request driver: offers the next byte once the previous one is taken
    always @(negedge aclk) begin
        msg_byte_t pending;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (req_sent == req_accepted) begin
            if (byte_queue.size() > 0 && !sender_idles()) begin
                pending = byte_queue.pop_front();
                s_valid <= 1'b1;
                s_data_byte <= pending.data;
                s_final_byte <= pending.fin;
                req_sent++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !receiver_stalls();
        end
    end

    // monitor: predict on accepted bytes, compare accepted characters
    always @(posedge aclk) begin
        enc_char_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                encode_byte(s_data_byte, s_final_byte);
                req_accepted++;
            end
            if (m_valid && m_ready) begin
                if (char_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %h run_last %b done %b",
                        m_out_char, m_run_last, m_message_done));
                end else begin
                    want = char_expect.pop_front();
                    if (m_out_char !== want.code || m_run_last !== want.run_last ||
                        m_message_done !== want.done)
                        report_mismatch($sformatf(
                            "char exp %h got %h, run_last exp %b got %b, done exp %b got %b",
                            want.code, m_out_char, want.run_last, m_run_last,
                            want.done, m_message_done));
                end
            end
        end
    end

    task automatic queue_byte(input logic [7:0] d, input logic fin);
        msg_byte_t b;
        b.data = d;
        b.fin = fin;
        byte_queue.push_back(b);
    endtask

    // random bytes, messages end at random so every group phase sees a final byte
    task automatic queue_random_bytes(input int count);
        for (int i = 0; i < count; i++)
            queue_byte(8'($urandom), $urandom_range(0, 5) == 0);
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || req_sent != req_accepted || char_expect.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_LEN) @(posedge aclk);
    endtask

    // register write while the block is idle
    task automatic write_reg(input logic idx, input logic [LINE_LEN_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_LINE_LENGTH)
            line_len_cfg = val;
        else
            fold_cfg = val[0];
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [LINE_LEN_W-1:0] pick_line_length();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LINE_LEN_W'($urandom_range(1, 8));
            2:       return LINE_LEN_W'(9);
            3:       return LINE_LEN_W'($urandom_range(10, 24));
            4:       return LINE_LEN_W'($urandom_range(25, 100));
            default: return LINE_LEN_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // test sequence
    initial begin
        repeat (RESET_LEN) @(negedge aclk);
        aresetn <= 1'b1;

        // reset config: one-, two-, three- and four-byte messages, all-zero and all-one bytes
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hEF, 1'b0);
        queue_byte(8'hBE, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_drained();

        // shortest wrapping line with folding
        write_reg(REG_LINE_LENGTH, LINE_LEN_W'(9));
        write_reg(REG_FOLD_TAB, LINE_LEN_W'(1));
        for (int i = 0; i < 9; i++)
            queue_byte(8'($urandom), i == 8);
        wait_drained();

        // line length 8 and below means no wrap
        write_reg(REG_LINE_LENGTH, LINE_LEN_W'(8));
        write_reg(REG_FOLD_TAB, LINE_LEN_W'(0));
        for (int i = 0; i < 5; i++)
            queue_byte(8'($urandom), i == 4);
        wait_drained();

        // wrapping switched on in the middle of a message
        write_reg(REG_LINE_LENGTH, LINE_LEN_W'(0));
        queue_random_bytes(0);
        for (int i = 0; i < 8; i++)
            queue_byte(8'($urandom), 1'b0);
        wait_drained();
        write_reg(REG_LINE_LENGTH, LINE_LEN_W'(9));
        for (int i = 0; i < 3; i++)
            queue_byte(8'($urandom), i == 2);
        wait_drained();

        // line length lowered in the middle of a message
        write_reg(REG_LINE_LENGTH, LINE_LEN_W'(40));
        for (int i = 0; i < 20; i++)
            queue_byte(8'($urandom), 1'b0);
        wait_drained();
        write_reg(REG_LINE_LENGTH, LINE_LEN_W'(12));
        for (int i = 0; i < 4; i++)
            queue_byte(8'($urandom), i == 3);
        wait_drained();

        // random phases over all idle patterns and register settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            idle_mode = idle_mode_t'(p % 4);
            write_reg(REG_LINE_LENGTH, pick_line_length());
            write_reg(REG_FOLD_TAB, LINE_LEN_W'($urandom_range(0, 1)));
            queue_random_bytes(PHASE_BYTES);
            // receiver holds off while the sender keeps offering
            if (p == 4)
                hold_requests++;
            wait_drained();
        end

        // long run with wrapping off, then a shorter line breaks at once
        idle_mode = IDLE_NONE;
        write_reg(REG_LINE_LENGTH, '0);
        write_reg(REG_FOLD_TAB, LINE_LEN_W'(1));
        for (int i = 0; i < RUN_BYTES; i++)
            queue_byte(8'($urandom), 1'b0);
        wait_drained();
        write_reg(REG_LINE_LENGTH, LINE_LEN_W'(24));
        for (int i = 0; i < 3; i++)
            queue_byte(8'($urandom), i == 2);
        wait_drained();

        if (mismatch_count == 0 && char_expect.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
